### rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// Phong point-light shader package
// Shared types, widths and constants for the shader front, queue, direction
// unit and back end.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Direction normalization widths
  localparam int MAG_W      = 24;
  localparam int SUM_W      = 50;
  localparam int ROOT_W     = 25;
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 15;
  localparam int UNIT_W     = 16;
  // Squares, sum, root digits, quotient digits
  localparam int UNIT_LAT   = 2 + SQRT_STEPS + DIV_STEPS;

  // Defaults
  localparam int SHIN_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Q2.16 constants
  localparam logic [17:0] ONE_Q16 = 18'd65536;
  localparam logic [17:0] SAT_Q16 = 18'd131072;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LIGHT_X = 3'd0,
    REG_LIGHT_Y = 3'd1,
    REG_LIGHT_Z = 3'd2,
    REG_RATIO   = 3'd3,
    REG_LIGHT_RGB = 3'd4,
    REG_EYE_X   = 3'd5,
    REG_EYE_Y   = 3'd6,
    REG_EYE_Z   = 3'd7
  } pps_reg_t;

  // Configuration register set
  typedef struct packed {
    logic [2:0][31:0] light_pos;
    logic [16:0]      ratio;
    logic [23:0]      light_rgb;
    logic [2:0][31:0] eye;
  } pps_cfg_t;

  // Prescaled direction: magnitudes below 2^24, signs, zero-length flag
  typedef struct packed {
    logic [2:0]            neg;
    logic                  zero;
    logic [2:0][MAG_W-1:0] mag;
  } pps_dir_t;

  // Item passed from front to back
  typedef struct packed {
    pps_dir_t         ldir;
    pps_dir_t         vdir;
    logic [2:0][15:0] nrm;
    logic [23:0]      surf;
    logic [7:0]       shin;
  } pps_item_t;

endpackage

### rtl/core/pps_front.sv
// ----------------------------------------------------------------------------
// Shader front end
// Accepts hit items, forms light and view directions and prescales them so
// every magnitude fits 24 bits; flags zero-length directions.
// ----------------------------------------------------------------------------
module pps_front import pps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pps_cfg_t          cfg_i,
  input  logic              push,
  output logic              full,
  input  logic [2:0][31:0]  point_i,
  input  logic [2:0][15:0]  nrm_i,
  input  logic [23:0]       surf_i,
  input  logic [7:0]        shin_i,
  output logic              q_push_o,
  output pps_item_t         q_item_o,
  input  logic              q_full_i
);

  // Magnitude, sign and shift to bring the largest magnitude below 2^24
  function automatic pps_dir_t norm_dir(input logic [2:0][32:0] d);
    pps_dir_t         r;
    logic [2:0][32:0] mag;
    logic [32:0]      orv;
    logic [3:0]       sh;
    orv = '0;
    sh  = '0;
    for (int i = 0; i < 3; i++) begin
      r.neg[i] = d[i][32];
      mag[i]   = d[i][32] ? (~d[i] + 33'd1) : d[i];
      orv      = orv | mag[i];
    end
    for (int j = MAG_W; j < 33; j++) begin
      if (orv[j]) sh = 4'(j - (MAG_W - 1));
    end
    r.zero = (orv == '0);
    for (int i = 0; i < 3; i++) begin
      r.mag[i] = MAG_W'(mag[i] >> sh);
    end
    return r;
  endfunction

  logic             en;
  logic             f0_v_r, f1_v_r;
  logic [2:0][32:0] dl_r, dv_r;
  logic [2:0][32:0] dl_nxt, dv_nxt;
  logic [2:0][15:0] nrm_r;
  logic [23:0]      surf_r;
  logic [7:0]       shin_r;
  pps_item_t        item_r;

  // Stall only when the last stage holds an item the queue cannot take
  assign en       = !(f1_v_r && q_full_i);
  assign full     = !en;
  assign q_push_o = f1_v_r && !q_full_i;
  assign q_item_o = item_r;

  // Direction differences, 33-bit two's complement
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dl_nxt[i] = {cfg_i.light_pos[i][31], cfg_i.light_pos[i]} - {point_i[i][31], point_i[i]};
      dv_nxt[i] = {cfg_i.eye[i][31], cfg_i.eye[i]} - {point_i[i][31], point_i[i]};
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
      f1_v_r <= 1'b0;
    end else if (en) begin
      f0_v_r <= push;
      f1_v_r <= f0_v_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      dl_r        <= dl_nxt;
      dv_r        <= dv_nxt;
      nrm_r       <= nrm_i;
      surf_r      <= surf_i;
      shin_r      <= shin_i;
      item_r.ldir <= norm_dir(dl_r);
      item_r.vdir <= norm_dir(dv_r);
      item_r.nrm  <= nrm_r;
      item_r.surf <= surf_r;
      item_r.shin <= shin_r;
    end
  end

endmodule

### rtl/core/pps_queue.sv
// ----------------------------------------------------------------------------
// Shader item queue
// Small FIFO between front and back, registered read data.
// ----------------------------------------------------------------------------
module pps_queue import pps_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_i,
  input  pps_item_t din_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output pps_item_t dout_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pps_item_t      mem [DEPTH];
  pps_item_t      dout_r;
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign full_o  = (cnt_r == CW'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign dout_o  = dout_r;

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (push_i) mem[wr_ptr_r] <= din_i;
    if (pop_i)  dout_r <= mem[rd_ptr_r];
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop_i)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/core/pps_unit.sv
// ----------------------------------------------------------------------------
// Direction normalizer
// Pipelined sum of squares, digit-by-digit square root and restoring
// division producing a Q2.14 unit vector; zero-length gives zero.
// ----------------------------------------------------------------------------
module pps_unit import pps_pkg::*; (
  input  logic                   clk,
  input  logic                   en_i,
  input  pps_dir_t               dir_i,
  output logic [2:0][UNIT_W-1:0] unit_o
);

  pps_dir_t                 dir_r [UNIT_LAT];
  logic [2:0][2*MAG_W-1:0]  sq_r;
  logic [SUM_W-1:0]         sum_r;
  logic [ROOT_W:0]          rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0]        root_r [SQRT_STEPS];
  logic [SUM_W-1:0]         rad_r  [SQRT_STEPS];
  logic [2:0][ROOT_W:0]     drem_r [DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] q_r   [DIV_STEPS];
  logic [ROOT_W-1:0]        len_r  [DIV_STEPS];

  // Side data shift line
  always_ff @(posedge clk) begin
    if (en_i) begin
      dir_r[0] <= dir_i;
      for (int t = 1; t < UNIT_LAT; t++) dir_r[t] <= dir_r[t-1];
    end
  end

  // Squares, then their sum
  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= dir_i.mag[i] * dir_i.mag[i];
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [ROOT_W:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  rad_in;
    logic [ROOT_W+2:0] cur, trial;
    logic              ge;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end
    assign cur   = {rem_in, rad_in[SUM_W-1:SUM_W-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cur >= trial);
    always_ff @(posedge clk) begin
      if (en_i) begin
        rem_r[k]  <= ge ? (ROOT_W+1)'(cur - trial) : (ROOT_W+1)'(cur);
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
        rad_r[k]  <= {rad_in[SUM_W-3:0], 2'b00};
      end
    end
  end

  // Quotient (mag << 14) / len, one bit per stage, three lanes
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [2:0][ROOT_W:0]      rem_in;
    logic [2:0][DIV_STEPS-1:0] q_in;
    logic [ROOT_W-1:0]         len_in;
    logic [2:0]                ge;
    if (j == 0) begin : g_first
      assign len_in = root_r[SQRT_STEPS-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = (ROOT_W+1)'(dir_r[SQRT_STEPS+1].mag[i]);
        assign q_in[i]   = '0;
      end
    end else begin : g_next
      assign len_in = len_r[j-1];
      assign rem_in = drem_r[j-1];
      assign q_in   = q_r[j-1];
    end
    always_comb begin
      for (int i = 0; i < 3; i++) ge[i] = (rem_in[i] >= {1'b0, len_in});
    end
    always_ff @(posedge clk) begin
      if (en_i) begin
        len_r[j] <= len_in;
        for (int i = 0; i < 3; i++) begin
          drem_r[j][i] <= ge[i] ? ((rem_in[i] - {1'b0, len_in}) << 1) : (rem_in[i] << 1);
          q_r[j][i]    <= {q_in[i][DIV_STEPS-2:0], ge[i]};
        end
      end
    end
  end

  // Apply sign, zero-length gives a zero vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dir_r[UNIT_LAT-1].zero) unit_o[i] = '0;
      else if (dir_r[UNIT_LAT-1].neg[i])
        unit_o[i] = UNIT_W'(-{1'b0, q_r[DIV_STEPS-1][i]});
      else unit_o[i] = UNIT_W'(q_r[DIV_STEPS-1][i]);
    end
  end

endmodule

### rtl/core/pps_back.sv
// ----------------------------------------------------------------------------
// Shader back end
// Normalizes directions, forms diffuse and reflected specular terms, raises
// specular to the shininess power and scales the surface color.
// ----------------------------------------------------------------------------
module pps_back import pps_pkg::*; #(
  parameter int SHININESS_BITS = SHIN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pps_cfg_t    cfg_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  input  pps_item_t   q_item_i,
  output logic        empty,
  input  logic        pop,
  output logic [23:0] shaded_rgb_o
);

  localparam int PW_STAGES = 2 * SHININESS_BITS;

  typedef struct packed {
    logic             v;
    logic [2:0][15:0] nrm;
    logic [23:0]      surf;
    logic [7:0]       shin;
  } sb_t;

  // Q2.16 product, truncated and saturated to 2.0
  function automatic logic [17:0] mul_sat(input logic [17:0] a, input logic [17:0] b);
    logic [35:0] p;
    p = a * b;
    return (p[35:16] > 20'(SAT_Q16)) ? SAT_Q16 : p[33:16];
  endfunction

  logic                   en;
  logic                   bq_v_r;
  sb_t                    sb_r [UNIT_LAT];
  logic [2:0][UNIT_W-1:0] lu, vu;

  // Dot product stages
  logic                   d1_v_r, d2_v_r, d3_v_r, d4_v_r, d5_v_r, d6_v_r;
  logic [2:0][15:0]       d1_l_r, d1_v3_r, d1_n_r, d2_l_r, d2_v3_r, d2_n_r;
  logic [2:0][15:0]       d3_l_r, d3_v3_r, d4_v3_r;
  logic signed [31:0]     nl_r [3];
  logic signed [31:0]     dnl_r;
  logic signed [47:0]     t_r [3];
  logic signed [33:0]     r28_r [3];
  logic signed [49:0]     p_r [3];
  logic [19:0]            d3_dt_r, d4_dt_r, d5_dt_r, d6_dt_r;
  logic [23:0]            d1_surf_r, d2_surf_r, d3_surf_r, d4_surf_r, d5_surf_r, d6_surf_r;
  logic [7:0]             d1_shin_r, d2_shin_r, d3_shin_r, d4_shin_r, d5_shin_r, d6_shin_r;
  logic [17:0]            base_r;
  logic [18:0]            dif;
  logic [35:0]            dt_prod;
  logic signed [51:0]     rv;
  logic [17:0]            base_nxt;

  // Power stages
  logic                   pv_r    [PW_STAGES];
  logic [17:0]            pw_r    [PW_STAGES];
  logic [17:0]            pbase_r [PW_STAGES];
  logic [7:0]             pshin_r [PW_STAGES];
  logic [19:0]            pdt_r   [PW_STAGES];
  logic [23:0]            psurf_r [PW_STAGES];

  // Color stages
  logic                   c1_v_r, c2_v_r, c3_v_r, out_v_r;
  logic [16:0]            inten_r;
  logic [2:0][15:0]       sl_r, y_r;
  logic [23:0]            c3_rgb_r, out_rgb_r;
  logic [20:0]            inten_sum;
  logic [16:0]            inten_nxt;

  // Whole pipeline advances unless a finished item is still waiting
  assign en           = !out_v_r || pop;
  assign q_pop_o      = en && !q_empty_i;
  assign empty        = !out_v_r;
  assign shaded_rgb_o = out_rgb_r;

  // Queue read stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) bq_v_r <= 1'b0;
    else if (en) bq_v_r <= !q_empty_i;
  end

  // Light and view normalizers
  pps_unit u_light (.clk(clk), .en_i(en), .dir_i(q_item_i.ldir), .unit_o(lu));
  pps_unit u_view  (.clk(clk), .en_i(en), .dir_i(q_item_i.vdir), .unit_o(vu));

  // Side data alongside the normalizers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < UNIT_LAT; t++) sb_r[t].v <= 1'b0;
    end else if (en) begin
      sb_r[0].v <= bq_v_r;
      for (int t = 1; t < UNIT_LAT; t++) sb_r[t].v <= sb_r[t-1].v;
    end
    if (en) begin
      sb_r[0].nrm  <= q_item_i.nrm;
      sb_r[0].surf <= q_item_i.surf;
      sb_r[0].shin <= q_item_i.shin;
      for (int t = 1; t < UNIT_LAT; t++) begin
        sb_r[t].nrm  <= sb_r[t-1].nrm;
        sb_r[t].surf <= sb_r[t-1].surf;
        sb_r[t].shin <= sb_r[t-1].shin;
      end
    end
  end

  // Diffuse term scaled by the light ratio
  assign dif     = (dnl_r > 0) ? 19'(dnl_r[30:12]) : '0;
  assign dt_prod = cfg_i.ratio * dif;

  // Specular base: R.V clipped at zero, Q2.16, saturated
  assign rv = 52'(p_r[0]) + 52'(p_r[1]) + 52'(p_r[2]);
  always_comb begin
    if (rv <= 0) base_nxt = '0;
    else if (rv[51:26] > 26'(SAT_Q16)) base_nxt = SAT_Q16;
    else base_nxt = rv[43:26];
  end

  // Dot product valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0; d2_v_r <= 1'b0; d3_v_r <= 1'b0;
      d4_v_r <= 1'b0; d5_v_r <= 1'b0; d6_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= sb_r[UNIT_LAT-1].v;
      d2_v_r <= d1_v_r;
      d3_v_r <= d2_v_r;
      d4_v_r <= d3_v_r;
      d5_v_r <= d4_v_r;
      d6_v_r <= d5_v_r;
    end
  end

  // N.L, reflection R = -L + 2(N.L)N and R.V
  always_ff @(posedge clk) begin
    if (en) begin
      // products N*L
      d1_l_r    <= lu;
      d1_v3_r   <= vu;
      d1_n_r    <= sb_r[UNIT_LAT-1].nrm;
      d1_surf_r <= sb_r[UNIT_LAT-1].surf;
      d1_shin_r <= sb_r[UNIT_LAT-1].shin;
      for (int i = 0; i < 3; i++) nl_r[i] <= $signed(sb_r[UNIT_LAT-1].nrm[i]) * $signed(lu[i]);
      // N.L sum
      dnl_r     <= nl_r[0] + nl_r[1] + nl_r[2];
      d2_l_r    <= d1_l_r;
      d2_v3_r   <= d1_v3_r;
      d2_n_r    <= d1_n_r;
      d2_surf_r <= d1_surf_r;
      d2_shin_r <= d1_shin_r;
      // (N.L)*N and diffuse scaling
      for (int i = 0; i < 3; i++) t_r[i] <= dnl_r * $signed(d2_n_r[i]);
      d3_dt_r   <= dt_prod[35:16];
      d3_l_r    <= d2_l_r;
      d3_v3_r   <= d2_v3_r;
      d3_surf_r <= d2_surf_r;
      d3_shin_r <= d2_shin_r;
      // reflected vector, floor to Q.28
      for (int i = 0; i < 3; i++) begin
        r28_r[i] <= 34'(((t_r[i] <<< 1) - (48'($signed(d3_l_r[i])) <<< 28)) >>> 14);
      end
      d4_dt_r   <= d3_dt_r;
      d4_v3_r   <= d3_v3_r;
      d4_surf_r <= d3_surf_r;
      d4_shin_r <= d3_shin_r;
      // products R*V
      for (int i = 0; i < 3; i++) p_r[i] <= r28_r[i] * $signed(d4_v3_r[i]);
      d5_dt_r   <= d4_dt_r;
      d5_surf_r <= d4_surf_r;
      d5_shin_r <= d4_shin_r;
      // base
      base_r    <= base_nxt;
      d6_dt_r   <= d5_dt_r;
      d6_surf_r <= d5_surf_r;
      d6_shin_r <= d5_shin_r;
    end
  end

  // Square-and-multiply, shininess bits from the top, one multiply per stage
  for (genvar t = 0; t < PW_STAGES; t++) begin : g_pow
    logic        v_in;
    logic [17:0] spec_in, base_in, spec_nxt;
    logic [7:0]  shin_in;
    logic [19:0] dt_in;
    logic [23:0] surf_in;
    if (t == 0) begin : g_first
      assign v_in    = d6_v_r;
      assign spec_in = ONE_Q16;
      assign base_in = base_r;
      assign shin_in = d6_shin_r;
      assign dt_in   = d6_dt_r;
      assign surf_in = d6_surf_r;
    end else begin : g_next
      assign v_in    = pv_r[t-1];
      assign spec_in = pw_r[t-1];
      assign base_in = pbase_r[t-1];
      assign shin_in = pshin_r[t-1];
      assign dt_in   = pdt_r[t-1];
      assign surf_in = psurf_r[t-1];
    end
    if (t % 2 == 0) begin : g_sq
      assign spec_nxt = mul_sat(spec_in, spec_in);
    end else begin : g_mul
      localparam int B = SHININESS_BITS - 1 - t / 2;
      if (B < 8) begin : g_bit
        assign spec_nxt = shin_in[B] ? mul_sat(spec_in, base_in) : spec_in;
      end else begin : g_nobit
        assign spec_nxt = spec_in;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) pv_r[t] <= 1'b0;
      else if (en) pv_r[t] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[t]    <= spec_nxt;
        pbase_r[t] <= base_in;
        pshin_r[t] <= shin_in;
        pdt_r[t]   <= dt_in;
        psurf_r[t] <= surf_in;
      end
    end
  end

  // Intensity, clamped to 1.0
  assign inten_sum = 21'(pdt_r[PW_STAGES-1]) + 21'(pw_r[PW_STAGES-1][17:1]);
  assign inten_nxt = (inten_sum > 21'(ONE_Q16)) ? 17'(ONE_Q16) : inten_sum[16:0];

  // Color stage valids and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r  <= 1'b0;
      c2_v_r  <= 1'b0;
      c3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r  <= pv_r[PW_STAGES-1];
      c2_v_r  <= c1_v_r;
      c3_v_r  <= c2_v_r;
      out_v_r <= c3_v_r;
    end
  end

  // Per channel: s*l, times intensity, divide by 255 via reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      inten_r   <= inten_nxt;
      out_rgb_r <= c3_rgb_r;
      for (int c = 0; c < 3; c++) begin
        sl_r[c]            <= psurf_r[PW_STAGES-1][c*8 +: 8] * cfg_i.light_rgb[c*8 +: 8];
        y_r[c]             <= 16'((33'(sl_r[c]) * 33'(inten_r)) >> 16);
        c3_rgb_r[c*8 +: 8] <= 8'((32'(y_r[c]) * 32'h8081) >> 23);
      end
    end
  end

endmodule

### rtl/core/phong_point_light_shader.sv
// ----------------------------------------------------------------------------
// Phong point-light shader
// Pipeline: 56 + 2*SHININESS_BITS register stages (2 front stages, queue
// write and read, 42-stage square root/divide normalizer, 6 dot product
// stages, 2 multiplies per shininess bit, 3 color stages, output).
// Throughput: one item per cycle while results are popped as they become
// ready; the back end is fully pipelined.
// Reset: queue and pipeline emptied, registers take their reset values.
// ----------------------------------------------------------------------------
module phong_point_light_shader import pps_pkg::*; #(
  parameter int SHININESS_BITS = SHIN_BITS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  // Input items
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [23:0]        in_surface_rgb,
  input  logic [7:0]         in_shininess,
  // Result items
  output logic               empty,
  input  logic               pop,
  output logic [23:0]        out_shaded_rgb
);

  pps_cfg_t  cfg_r;
  logic      q_push, q_full, q_pop, q_empty;
  pps_item_t q_din, q_dout;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_pos <= '0;
      cfg_r.ratio     <= 17'(ONE_Q16);
      cfg_r.light_rgb <= 24'hFFFFFF;
      cfg_r.eye       <= '0;
    end else if (cfg_we) begin
      unique case (pps_reg_t'(cfg_idx))
        REG_LIGHT_X:   cfg_r.light_pos[0] <= cfg_data;
        REG_LIGHT_Y:   cfg_r.light_pos[1] <= cfg_data;
        REG_LIGHT_Z:   cfg_r.light_pos[2] <= cfg_data;
        REG_RATIO:     cfg_r.ratio        <= cfg_data[16:0];
        REG_LIGHT_RGB: cfg_r.light_rgb    <= cfg_data[23:0];
        REG_EYE_X:     cfg_r.eye[0]       <= cfg_data;
        REG_EYE_Y:     cfg_r.eye[1]       <= cfg_data;
        REG_EYE_Z:     cfg_r.eye[2]       <= cfg_data;
      endcase
    end
  end

  // Front: direction setup
  pps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg_r),
    .push     (push),
    .full     (full),
    .point_i  ({in_point_z, in_point_y, in_point_x}),
    .nrm_i    ({in_normal_z, in_normal_y, in_normal_x}),
    .surf_i   (in_surface_rgb),
    .shin_i   (in_shininess),
    .q_push_o (q_push),
    .q_item_o (q_din),
    .q_full_i (q_full)
  );

  // Queue between front and back
  pps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .dout_o  (q_dout)
  );

  // Back: shading
  pps_back #(.SHININESS_BITS(SHININESS_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_item_i     (q_dout),
    .empty        (empty),
    .pop          (pop),
    .shaded_rgb_o (out_shaded_rgb)
  );

endmodule
